[rtl/core/sfs_pkg.sv]
// Package for the stream field selector: configuration register codes,
// sizing constants and the structs passed between its modules.
// No dependencies.
package sfs_pkg;

  localparam int MaxFields  = 64;
  localparam int DelimBytes = 4;
  localparam int RegBytes   = 4;
  localparam int DelimCap   = (DelimBytes < RegBytes) ? DelimBytes : RegBytes;
  localparam int BurstLen   = DelimCap + 1;
  localparam int CntW       = $clog2(BurstLen + 1);
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 3;

  localparam logic [7:0] NlByte   = 8'd10;
  localparam logic [6:0] TokenSat = 7'd127;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIELD_MASK     = 3'd0,
    REG_IN_DELIMS      = 3'd1,
    REG_IN_DELIM_COUNT = 3'd2,
    REG_OUT_DELIM      = 3'd3,
    REG_OUT_DELIM_LEN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] field_mask;
    logic [31:0] in_delims;
    logic [2:0]  in_delim_count;
    logic [31:0] out_delim;
    logic [2:0]  out_delim_len;
  } cfg_t;

  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } burst_t;

  function automatic logic [2:0] cap_count(logic [2:0] n);
    logic [2:0] lim;
    lim = 3'(DelimCap);
    return (n > lim) ? lim : n;
  endfunction

endpackage

[rtl/core/sfs_in_if.sv]
// Input byte channel of the stream field selector.
// No dependencies.
interface sfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/core/sfs_out_if.sv]
// Result byte channel of the stream field selector.
// No dependencies.
interface sfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

[rtl/core/sfs_cfg_regs.sv]
// Configuration registers of the stream field selector.
// Depends on sfs_pkg.
module sfs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output sfs_pkg::cfg_t                 cfg_o
);
  import sfs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_mask     <= '0;
      cfg_q.in_delims      <= 32'd32;
      cfg_q.in_delim_count <= 3'd1;
      cfg_q.out_delim      <= 32'd32;
      cfg_q.out_delim_len  <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIELD_MASK:     cfg_q.field_mask     <= cfg_wdata_i;
        REG_IN_DELIMS:      cfg_q.in_delims      <= cfg_wdata_i[31:0];
        REG_IN_DELIM_COUNT: cfg_q.in_delim_count <= cfg_wdata_i[2:0];
        REG_OUT_DELIM:      cfg_q.out_delim      <= cfg_wdata_i[31:0];
        REG_OUT_DELIM_LEN:  cfg_q.out_delim_len  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/sfs_parser.sv]
// Input register, line/token state and burst builder of the field selector.
// Depends on sfs_pkg and sfs_in_if.
module sfs_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfs_in_if.sink         in_if,
  input  sfs_pkg::cfg_t  cfg_i,
  input  logic           free_i,
  output sfs_pkg::burst_t burst_o
);
  import sfs_pkg::*;

  logic       vld_q;
  logic [7:0] byte_q;
  logic [6:0] tn_q, tn_d;
  logic       inside_q, inside_d;
  logic       chosen_q, chosen_d;
  logic       sent_q, sent_d;

  logic                     is_nl, is_delim, emit, consume;
  logic [2:0]               in_cnt, dlen;
  logic [RegBytes-1:0][7:0] idel, odel;
  burst_t                   burst;

  assign idel = cfg_i.in_delims;
  assign odel = cfg_i.out_delim;

  always_comb begin
    is_nl    = (byte_q == NlByte);
    in_cnt   = cap_count(cfg_i.in_delim_count);
    is_delim = 1'b0;
    for (int i = 0; i < DelimCap; i++) begin
      if ((3'(i) < in_cnt) && (idel[i] == byte_q)) is_delim = 1'b1;
    end

    tn_d     = tn_q;
    inside_d = inside_q;
    chosen_d = chosen_q;
    sent_d   = sent_q;
    dlen     = '0;
    if (is_nl) begin
      tn_d     = '0;
      inside_d = 1'b0;
      chosen_d = 1'b0;
      sent_d   = 1'b0;
    end else if (is_delim) begin
      inside_d = 1'b0;
    end else if (!inside_q) begin
      inside_d = 1'b1;
      tn_d     = (tn_q == TokenSat) ? tn_q : tn_q + 7'd1;
      chosen_d = (tn_d <= 7'(MaxFields)) && cfg_i.field_mask[6'(tn_d - 7'd1)];
      if (chosen_d) begin
        if (sent_q) dlen = cap_count(cfg_i.out_delim_len);
        sent_d = 1'b1;
      end
    end

    emit = is_nl || (!is_delim && chosen_d);
    for (int i = 0; i < BurstLen; i++) begin
      burst.bytes[i] = byte_q;
      if ((i < DelimCap) && (3'(i) < dlen)) burst.bytes[i] = odel[2'(i)];
    end
    burst.cnt = (vld_q && emit) ? CntW'(dlen) + CntW'(1) : '0;
  end

  assign consume     = vld_q && (!emit || free_i);
  assign in_if.ready = !vld_q || consume;
  assign burst_o     = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      tn_q     <= '0;
      inside_q <= 1'b0;
      chosen_q <= 1'b0;
      sent_q   <= 1'b0;
    end else begin
      if (consume) begin
        tn_q     <= tn_d;
        inside_q <= inside_d;
        chosen_q <= chosen_d;
        sent_q   <= sent_d;
      end
      if (in_if.ready) vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) byte_q <= in_if.data_byte;
  end

endmodule

[rtl/core/sfs_emitter.sv]
// Result register and byte serializer of the field selector.
// Depends on sfs_pkg and sfs_out_if.
module sfs_emitter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfs_pkg::burst_t  burst_i,
  output logic             free_o,
  sfs_out_if.source        out_if
);
  import sfs_pkg::*;

  logic [BurstLen-1:0][7:0] bytes_q;
  logic [CntW-1:0]          cnt_q;
  logic                     load, shift;

  assign shift  = out_if.valid && out_if.ready;
  assign free_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_if.ready);
  assign load   = free_o && (burst_i.cnt != '0);

  assign out_if.valid    = (cnt_q != '0);
  assign out_if.out_byte = bytes_q[0];
  assign out_if.run_last = (cnt_q == CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= burst_i.cnt;
    end else if (shift) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= burst_i.bytes;
    end else if (shift) begin
      for (int i = 0; i < BurstLen - 1; i++) bytes_q[i] <= bytes_q[i+1];
    end
  end

endmodule

[rtl/core/stream_field_selector.sv]
// Stream field selector top level: cut-style token selection on a byte stream.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if, sfs_cfg_regs, sfs_parser, sfs_emitter.
//
// Bytes enter one per cycle through an input register, while the output does
// not hold them back; a result register then sends the bytes each input
// causes, one per cycle while out_if.ready is high, with run_last on the
// final one. Delimiters and bytes of unselected tokens produce nothing. A
// byte of a selected token or a newline produces one result byte; the first
// byte of a selected token that follows an earlier selected token of the line
// also produces min(out_delim_len, 4) output delimiter bytes before itself, and
// a following byte that produces output waits until the serializer is through.
// The user must write configuration only while the stream is idle; the block itself does not enforce it.
module stream_field_selector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  sfs_in_if.sink                        in_if,
  sfs_out_if.source                     out_if
);
  import sfs_pkg::*;

  cfg_t   cfg;
  burst_t burst;
  logic   free;

  sfs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sfs_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .cfg_i   (cfg),
    .free_i  (free),
    .burst_o (burst)
  );

  sfs_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .burst_i (burst),
    .free_o  (free),
    .out_if  (out_if)
  );

endmodule

[tb/sfs_tb_pkg.sv]
// Scoreboard for the stream field selector testbench: line-state predictor
// and the queue of expected output bytes. Depends on sfs_pkg.
package sfs_tb_pkg;
  import sfs_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } sel_byte_t;

  class sfs_byte_scoreboard;
    logic [63:0] field_mask;
    logic [31:0] in_delims;
    logic [2:0]  in_delim_count;
    logic [31:0] out_delim;
    logic [2:0]  out_delim_len;

    logic [6:0]  token_num;
    bit          in_token;
    bit          token_sel;
    bit          line_sent;

    sel_byte_t   expected_q[$];
    int          errors;

    function new();
      field_mask     = '0;
      in_delims      = 32'd32;
      in_delim_count = 3'd1;
      out_delim      = 32'd32;
      out_delim_len  = 3'd1;
      errors         = 0;
      clear_line();
    endfunction

    function void clear_line();
      token_num = '0;
      in_token  = 1'b0;
      token_sel = 1'b0;
      line_sent = 1'b0;
    endfunction

    function int capped(logic [2:0] n);
      return (int'(n) > DelimCap) ? DelimCap : int'(n);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] v);
      case (idx)
        REG_FIELD_MASK:     field_mask     = v;
        REG_IN_DELIMS:      in_delims      = v[31:0];
        REG_IN_DELIM_COUNT: in_delim_count = v[2:0];
        REG_OUT_DELIM:      out_delim      = v[31:0];
        REG_OUT_DELIM_LEN:  out_delim_len  = v[2:0];
        default: ;
      endcase
    endfunction

    function bit is_delim(logic [7:0] b);
      for (int i = 0; i < capped(in_delim_count); i++) begin
        if (in_delims[8*i +: 8] == b) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic [7:0] b);
      sel_byte_t burst[$];
      sel_byte_t item;
      if (b == NlByte) begin
        clear_line();
        item.out_byte = NlByte;
        item.run_last = 1'b1;
        expected_q.push_back(item);
        return;
      end
      if (is_delim(b)) begin
        in_token = 1'b0;
        return;
      end
      if (!in_token) begin
        in_token = 1'b1;
        if (token_num < TokenSat) token_num++;
        token_sel = 1'b0;
        if (token_num >= 1 && int'(token_num) <= MaxFields) begin
          token_sel = field_mask[token_num - 1];
        end
        if (token_sel) begin
          if (line_sent) begin
            for (int i = 0; i < capped(out_delim_len); i++) begin
              item.out_byte = out_delim[8*i +: 8];
              item.run_last = 1'b0;
              burst.push_back(item);
            end
          end
          line_sent = 1'b1;
        end
      end
      if (token_sel) begin
        item.out_byte = b;
        item.run_last = 1'b0;
        burst.push_back(item);
      end
      for (int i = 0; i < burst.size(); i++) begin
        item = burst[i];
        item.run_last = (i == burst.size() - 1);
        expected_q.push_back(item);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] ob, logic rl);
      sel_byte_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %h last %b", ob, rl));
        return;
      end
      want = expected_q.pop_front();
      if (ob !== want.out_byte)
        report_mismatch($sformatf("out_byte %h, want %h", ob, want.out_byte));
      if (rl !== want.run_last)
        report_mismatch($sformatf("run_last %b, want %b (byte %h)", rl, want.run_last, ob));
    endtask

    task flush_leftovers();
      sel_byte_t want;
      while (expected_q.size() != 0) begin
        want = expected_q.pop_front();
        report_mismatch($sformatf("missing byte %h last %b", want.out_byte, want.run_last));
      end
    endtask
  endclass

endpackage

[tb/tb.sv]
// Top-level testbench for stream_field_selector: directed lines, a line past
// the field limit and randomized configurations with idling on both channels.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if and sfs_tb_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfs_pkg::*;
  import sfs_tb_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  sfs_in_if  in_if ();
  sfs_out_if out_if ();

  stream_field_selector u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  sfs_byte_scoreboard sb;
  logic [7:0]  stream_q[$];
  logic [31:0] cur_in_delims = 32'd32;
  logic [2:0]  cur_in_cnt = 3'd1;
  bit          steady = 1'b0;
  int          stall_left = 0;
  int unsigned cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.out_byte, out_if.run_last);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  function automatic bit is_cur_delim(logic [7:0] b);
    int n;
    n = (cur_in_cnt > 3'(DelimCap)) ? DelimCap : int'(cur_in_cnt);
    for (int i = 0; i < n; i++) begin
      if (cur_in_delims[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] delim_byte();
    int n;
    logic [7:0] x;
    n = (cur_in_cnt > 3'(DelimCap)) ? DelimCap : int'(cur_in_cnt);
    if (n == 0) begin
      x = 8'($urandom_range(0, 255));
      return (x == NlByte) ? 8'd11 : x;
    end
    return cur_in_delims[8*$urandom_range(0, n - 1) +: 8];
  endfunction

  function automatic logic [7:0] token_byte();
    logic [7:0] x;
    x = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 6) return x;
    for (int i = 0; i < 8; i++) begin
      if (!is_cur_delim(x) && x != NlByte) return x;
      x = 8'($urandom_range(0, 255));
    end
    return x;
  endfunction

  function automatic void add_line(int n_tok, int max_len);
    repeat ($urandom_range(0, 2)) stream_q.push_back(delim_byte());
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 3)) stream_q.push_back(delim_byte());
      repeat ($urandom_range(1, max_len)) stream_q.push_back(token_byte());
    end
    repeat ($urandom_range(0, 1)) stream_q.push_back(delim_byte());
    stream_q.push_back(NlByte);
  endfunction

  task automatic put_reg(cfg_reg_e idx, logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic write_config(logic [63:0] mask, logic [31:0] ind, logic [2:0] inc,
                              logic [31:0] od, logic [2:0] odl);
    put_reg(REG_FIELD_MASK, mask);
    put_reg(REG_IN_DELIMS, {32'd0, ind});
    put_reg(REG_IN_DELIM_COUNT, {61'd0, inc});
    put_reg(REG_OUT_DELIM, {32'd0, od});
    put_reg(REG_OUT_DELIM_LEN, {61'd0, odl});
    cfg_we_i      <= 1'b0;
    cur_in_delims = ind;
    cur_in_cnt    = inc;
  endtask

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(b);
    gap = pick_gap();
    if (gap > 0 || last) in_if.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_delims();
    logic [31:0] v;
    int r;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 9);
      v[8*i +: 8] = (r == 0) ? NlByte : (r == 1) ? 8'h00 : 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  initial begin
    logic [63:0] mask;
    logic [31:0] ind;
    sb = new();
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all fields, newline in the delimiter set, zero byte as token data, long output delimiter
    write_config('1, 32'h000A2C20, 3'd3, 32'hFF003A7C, 3'd7);
    stream_q = '{8'h0A, 8'h20, 8'h2C, 8'h0A, 8'h2C, 8'h61, 8'h20, 8'h2C, 8'h20,
                 8'h00, 8'hFF, 8'h2C, 8'h63, 8'h0A};
    send_stream();
    wait_drained();

    // no input delimiters: the whole line is one token
    write_config(64'h1, 32'h20202020, 3'd0, 32'h2D2D2D2D, 3'd2);
    stream_q = '{8'h61, 8'h20, 8'h62, 8'h0A};
    send_stream();
    wait_drained();

    // empty output delimiter, first token unselected
    write_config(64'h6, 32'h00000020, 3'd1, 32'h0000002C, 3'd0);
    stream_q = '{8'h61, 8'h20, 8'h62, 8'h20, 8'h63, 8'h20, 8'h64, 8'h0A};
    send_stream();
    wait_drained();

    // tokens past the field limit
    mask = {1'b1, 31'($urandom), 31'($urandom), 1'b1};
    ind  = {16'h0000, 8'h3B, 8'h09};
    write_config(mask, ind, 3'd2, $urandom, 3'd1);
    for (int t = 0; t < 66; t++) begin
      if (t > 0) stream_q.push_back(delim_byte());
      stream_q.push_back(token_byte());
    end
    stream_q.push_back(NlByte);
    send_stream();
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      steady = (p == 3);
      case (p % 4)
        0:       mask = '1;
        1:       mask = '0;
        2:       mask = {$urandom, $urandom};
        default: mask = {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      ind = rand_delims();
      write_config(mask, ind, (p == 0) ? 3'd4 : (p == 1) ? 3'd7 : (p == 2) ? 3'd0 :
                   3'($urandom_range(0, 7)), $urandom, 3'(p));
      while (stream_q.size() < 4) begin
        if ($urandom_range(0, 9) == 0) add_line(0, 1);
        else add_line($urandom_range(1, 3), ($urandom_range(0, 4) == 0) ? 6 : 3);
      end
      send_stream();
      wait_drained();
    end
    steady = 1'b0;

    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
